/* design/rmhs_pkg.sv */
// Package for the running median half sums unit.
// Holds item types, status and state codes, and the cell control struct.
// No dependencies.
`default_nettype none

package rmhs_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_ERASE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } rmhs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM
  } rmhs_state_e;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } rmhs_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] median;
    logic signed [SUM_W-1:0]   low_half_sum;
    logic signed [SUM_W-1:0]   high_half_sum;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic [STATUS_W-1:0]       status;
  } rmhs_out_t;

  typedef struct packed {
    logic commit;
    logic erase;
  } rmhs_cell_ctl_t;

endpackage

`default_nettype wire

/* design/rmhs_stream_if.sv */
// Valid/ready stream interface used for the input and result channels.
// The payload type is set at instantiation, normally from rmhs_pkg.
`default_nettype none

interface rmhs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/running_median_half_sums_unit.sv */
// Top level of the running median half sums unit: FSM, cell row and sums.
// Depends on rmhs_pkg, rmhs_stream_if and rmhs_cell.
//
// Each item passes through a shift state and then a sum state: in the shift
// state, every cell compares its entry with the value and the row shifts by
// one place to insert or erase it; in the sum state, the new lower median and
// its upper neighbor are read from the row and the two half sums are updated
// from them. The result then sits in an output register, and the next item is
// accepted in the sum state whenever the output register is free. The store
// starts empty after reset with no clearing pass.
`default_nettype none

module running_median_half_sums_unit #(
  parameter int unsigned CAPACITY   = rmhs_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = rmhs_pkg::VALUE_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rmhs_stream_if.sink   in_i,
  rmhs_stream_if.source out_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = rmhs_pkg::SUM_W;
  localparam int unsigned EW = (VB > SW) ? VB : SW;
  localparam int unsigned MW = (VB > rmhs_pkg::VALUE_W) ? VB : rmhs_pkg::VALUE_W;

  rmhs_pkg::rmhs_state_e  state_q, state_d;
  rmhs_pkg::rmhs_status_e status_q, status_d;
  rmhs_pkg::rmhs_out_t    out_q, out_d;
  rmhs_pkg::rmhs_cell_ctl_t ctl;

  logic                 kind_q;
  logic signed [VB-1:0] key_q;
  logic [CW-1:0]        count_q, count_d;
  logic [SW-1:0]        lower_q, lower_d;
  logic [SW-1:0]        total_q, total_d;
  logic                 commit_q, commit_d;
  logic                 out_valid_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 load_out;
  logic                 found;
  logic [MW-1:0]        in_wide;
  logic [CW-1:0]        mid_idx;

  logic signed [VB-1:0] q_vec    [CAPACITY];
  logic                 le_vec   [CAPACITY];
  logic                 eq_vec   [CAPACITY];
  logic signed [VB-1:0] rdm_vec  [CAPACITY];
  logic signed [VB-1:0] rdn_vec  [CAPACITY];

  logic signed [VB-1:0] med_val;
  logic signed [VB-1:0] nxt_val;
  logic signed [EW-1:0] key_w, med_w, nxt_w;
  logic signed [MW-1:0] med_out_w;
  logic [SW-1:0]        key_s, med_s, nxt_s;

  // Handshake and control.
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == rmhs_pkg::S_IDLE) ||
                      ((state_q == rmhs_pkg::S_SUM) && out_free);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign load_out = (state_q == rmhs_pkg::S_SUM) && out_free;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rmhs_pkg::S_IDLE: begin
        if (in_xfer) state_d = rmhs_pkg::S_SHIFT;
      end
      rmhs_pkg::S_SHIFT: begin
        state_d = rmhs_pkg::S_SUM;
      end
      rmhs_pkg::S_SUM: begin
        if (in_xfer) begin
          state_d = rmhs_pkg::S_SHIFT;
        end else if (out_free) begin
          state_d = rmhs_pkg::S_IDLE;
        end
      end
      default: state_d = rmhs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      found = found | eq_vec[i];
    end
  end

  always_comb begin
    ctl      = '0;
    commit_d = commit_q;
    status_d = status_q;
    count_d  = count_q;
    case (state_q)
      rmhs_pkg::S_SHIFT: begin
        ctl.erase = (kind_q == rmhs_pkg::KIND_ERASE);
        if (kind_q == rmhs_pkg::KIND_INSERT) begin
          ctl.commit = count_q < CW'(CAPACITY);
          status_d   = ctl.commit ? rmhs_pkg::ST_DONE : rmhs_pkg::ST_FULL;
          count_d    = ctl.commit ? CW'(count_q + CW'(1)) : count_q;
        end else begin
          ctl.commit = found;
          status_d   = found ? rmhs_pkg::ST_DONE : rmhs_pkg::ST_ABSENT;
          count_d    = found ? CW'(count_q - CW'(1)) : count_q;
        end
        commit_d = ctl.commit;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Row of cells.
  assign in_wide = MW'(unsigned'(in_i.payload.value));
  assign mid_idx = CW'((count_q - CW'(1)) >> 1);

  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic signed [VB-1:0] left_q;
    logic                 left_le;
    logic signed [VB-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q  = '0;
      assign left_le = 1'b1;
    end else begin : g_inner
      assign left_q  = q_vec[g-1];
      assign left_le = le_vec[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_last
      assign right_q = q_vec[g];
    end else begin : g_body
      assign right_q = q_vec[g+1];
    end
    rmhs_cell #(
      .VB  (VB),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .key_i     (key_q),
      .count_i   (count_q),
      .rd_idx_i  (mid_idx),
      .left_q_i  (left_q),
      .left_le_i (left_le),
      .right_q_i (right_q),
      .q_o       (q_vec[g]),
      .le_o      (le_vec[g]),
      .eq_o      (eq_vec[g]),
      .rd_m_o    (rdm_vec[g]),
      .rd_n_o    (rdn_vec[g])
    );
  end

  always_comb begin
    med_val = '0;
    nxt_val = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      med_val = med_val | rdm_vec[i];
      nxt_val = nxt_val | rdn_vec[i];
    end
  end

  // Sum update from the median and its upper neighbor after the shift.
  assign key_w = EW'(key_q);
  assign med_w = EW'(med_val);
  assign nxt_w = EW'(nxt_val);
  assign key_s = key_w[SW-1:0];
  assign med_s = med_w[SW-1:0];
  assign nxt_s = nxt_w[SW-1:0];
  assign med_out_w = MW'(med_val);

  always_comb begin
    lower_d = lower_q;
    total_d = total_q;
    if (commit_q) begin
      if (count_q == '0) begin
        lower_d = '0;
        total_d = '0;
      end else if (kind_q == rmhs_pkg::KIND_INSERT) begin
        total_d = total_q + key_s;
        if (count_q[0]) begin
          lower_d = lower_q + ((med_val < key_q) ? med_s : key_s);
        end else if (nxt_val > key_q) begin
          lower_d = lower_q + key_s - nxt_s;
        end
      end else begin
        total_d = total_q - key_s;
        if (!count_q[0]) begin
          lower_d = lower_q - ((nxt_val < key_q) ? nxt_s : key_s);
        end else if (med_val > key_q) begin
          lower_d = lower_q + med_s - key_s;
        end
      end
    end
  end

  always_comb begin
    out_d.median        = (count_q == '0) ? '0 : med_out_w[rmhs_pkg::VALUE_W-1:0];
    out_d.low_half_sum  = lower_d;
    out_d.high_half_sum = total_d - lower_d;
    out_d.entry_count   = rmhs_pkg::COUNT_W'(count_q);
    out_d.is_empty      = (count_q == '0);
    out_d.status        = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmhs_pkg::S_IDLE;
      status_q    <= rmhs_pkg::ST_DONE;
      count_q     <= '0;
      lower_q     <= '0;
      total_q     <= '0;
      commit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      commit_q <= commit_d;
      if (load_out) begin
        lower_q     <= lower_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= in_i.payload.kind;
      key_q  <= in_wide[VB-1:0];
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_accept_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == rmhs_pkg::S_SHIFT)
    else $error("Accepted transfer did not start the shift cycle.");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmhs_pkg::S_SHIFT && !ctl.commit) |=> count_q == $past(count_q))
    else $error("Entry count changed on a refused or absent item.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.is_empty == (out_q.entry_count == '0)))
    else $error("Empty flag disagrees with entry count.");
`endif

endmodule

`default_nettype wire

/* design/rmhs_cell.sv */
// One cell of the sorted row: holds a single entry, compares it with the key
// and takes its neighbor's entry to open or close a gap. Uses rmhs_pkg.
`default_nettype none

module rmhs_cell #(
  parameter int unsigned VB  = rmhs_pkg::VALUE_BITS_DEF,
  parameter int unsigned CW  = rmhs_pkg::COUNT_W,
  parameter int unsigned IDX = 0
) (
  input  wire logic                     clk_i,
  input  wire rmhs_pkg::rmhs_cell_ctl_t ctl_i,
  input  wire logic signed [VB-1:0]     key_i,
  input  wire logic [CW-1:0]            count_i,
  input  wire logic [CW-1:0]            rd_idx_i,
  input  wire logic signed [VB-1:0]     left_q_i,
  input  wire logic                     left_le_i,
  input  wire logic signed [VB-1:0]     right_q_i,
  output logic signed [VB-1:0]          q_o,
  output logic                          le_o,
  output logic                          eq_o,
  output logic signed [VB-1:0]          rd_m_o,
  output logic signed [VB-1:0]          rd_n_o
);

  logic signed [VB-1:0] entry_q;
  logic signed [VB-1:0] entry_d;
  logic                 held;
  logic                 lt;
  logic [CW-1:0]        own_idx;

  assign own_idx = CW'(IDX);
  assign held    = own_idx < count_i;
  assign le_o    = held && (entry_q <= key_i);
  assign lt      = held && (entry_q < key_i);
  assign eq_o    = held && (entry_q == key_i);
  assign q_o     = entry_q;

  always_comb begin
    if (ctl_i.erase) begin
      entry_d = lt ? entry_q : right_q_i;
    end else begin
      entry_d = le_o ? entry_q : (left_le_i ? key_i : left_q_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      entry_q <= entry_d;
    end
  end

  assign rd_m_o = (own_idx == rd_idx_i) ? entry_q : '0;
  assign rd_n_o = (own_idx == CW'(rd_idx_i + CW'(1))) ? entry_q : '0;

endmodule

`default_nettype wire

/* tb/tb_running_median_half_sums_unit.sv */
// Self-checking testbench for running_median_half_sums_unit: directed table, random traffic, full store.
// Depends on rmhs_pkg, rmhs_stream_if and the unit itself; a queue-based sorted store predicts
// the results the table does not give; all are checked field by field in arrival order.
`default_nettype none

module tb_running_median_half_sums_unit;

  localparam int unsigned STORE_DEPTH = rmhs_pkg::CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    rmhs_pkg::rmhs_in_t  item;
    bit                  typed;
    rmhs_pkg::rmhs_out_t result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;
  int unsigned errors;
  int unsigned cycles;

  logic signed [rmhs_pkg::VALUE_W-1:0] sorted_vals[$];
  rmhs_pkg::rmhs_out_t                 pending_results[$];
  stim_row_t                           dir_rows[$];

  rmhs_stream_if #(.payload_t(rmhs_pkg::rmhs_in_t))  stim_if ();
  rmhs_stream_if #(.payload_t(rmhs_pkg::rmhs_out_t)) res_if ();

  running_median_half_sums_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stim_if),
    .out_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_running_median_half_sums_unit failed");
      $finish;
    end
  end

  function automatic rmhs_pkg::rmhs_out_t mk_result(
      input logic [rmhs_pkg::VALUE_W-1:0] med, input longint lo, input longint hi,
      input int cnt, input bit emp, input rmhs_pkg::rmhs_status_e st);
    rmhs_pkg::rmhs_out_t r;
    r.median        = med;
    r.low_half_sum  = lo[rmhs_pkg::SUM_W-1:0];
    r.high_half_sum = hi[rmhs_pkg::SUM_W-1:0];
    r.entry_count   = cnt[rmhs_pkg::COUNT_W-1:0];
    r.is_empty      = emp;
    r.status        = st;
    return r;
  endfunction

  function automatic rmhs_pkg::rmhs_in_t mk_item(input logic kind,
                                                 input logic [rmhs_pkg::VALUE_W-1:0] value);
    rmhs_pkg::rmhs_in_t it;
    it.kind  = kind;
    it.value = value;
    return it;
  endfunction

  function automatic void add_row(input logic kind, input logic [rmhs_pkg::VALUE_W-1:0] value,
                                  input bit typed, input rmhs_pkg::rmhs_out_t result);
    stim_row_t row;
    row.item   = mk_item(kind, value);
    row.typed  = typed;
    row.result = result;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_table();
    rmhs_pkg::rmhs_out_t none;
    none = '0;
    add_row(rmhs_pkg::KIND_ERASE,  32'd5,          1,
            mk_result(32'd0, 0, 0, 0, 1, rmhs_pkg::ST_ABSENT));
    add_row(rmhs_pkg::KIND_INSERT, 32'h7FFF_FFFF,  1,
            mk_result(32'h7FFF_FFFF, 64'sh7FFF_FFFF, 0, 1, 0, rmhs_pkg::ST_DONE));
    add_row(rmhs_pkg::KIND_INSERT, 32'h8000_0000,  1,
            mk_result(32'h8000_0000, -64'sh8000_0000, 64'sh7FFF_FFFF, 2, 0,
                      rmhs_pkg::ST_DONE));
    add_row(rmhs_pkg::KIND_INSERT, 32'd0,          1,
            mk_result(32'd0, -64'sh8000_0000, 64'sh7FFF_FFFF, 3, 0, rmhs_pkg::ST_DONE));
    add_row(rmhs_pkg::KIND_INSERT, 32'd0,          1,
            mk_result(32'd0, -64'sh8000_0000, 64'sh7FFF_FFFF, 4, 0, rmhs_pkg::ST_DONE));
    add_row(rmhs_pkg::KIND_ERASE,  32'd0,          0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'd7,          0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'h7FFF_FFFF,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'h8000_0000,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'd0,          1,
            mk_result(32'd0, 0, 0, 0, 1, rmhs_pkg::ST_DONE));
    add_row(rmhs_pkg::KIND_ERASE,  32'd0,          1,
            mk_result(32'd0, 0, 0, 0, 1, rmhs_pkg::ST_ABSENT));
    add_row(rmhs_pkg::KIND_INSERT, 32'hFFFF_FFFF,  0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'hFFFF_FFFF,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'hFFFF_FFFF,  0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'd1,          0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'd2,          0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'hFFFF_FFFD,  0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'h5555_5555,  0, none);
    add_row(rmhs_pkg::KIND_INSERT, 32'hAAAA_AAAA,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'hAAAA_AAAA,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'd2,          0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'd1,          0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'hFFFF_FFFD,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'h5555_5555,  0, none);
    add_row(rmhs_pkg::KIND_ERASE,  32'hFFFF_FFFF,  1,
            mk_result(32'd0, 0, 0, 0, 1, rmhs_pkg::ST_DONE));
  endfunction

  function automatic rmhs_pkg::rmhs_out_t update_median_store(input rmhs_pkg::rmhs_in_t it);
    rmhs_pkg::rmhs_out_t               r;
    logic signed [rmhs_pkg::SUM_W-1:0] lo_sum;
    logic signed [rmhs_pkg::SUM_W-1:0] hi_sum;
    int                                pos;
    int                                n;
    r      = '0;
    lo_sum = '0;
    hi_sum = '0;
    r.status = rmhs_pkg::ST_DONE;
    if (it.kind == rmhs_pkg::KIND_INSERT) begin
      if (sorted_vals.size() >= STORE_DEPTH) begin
        r.status = rmhs_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_vals.size() && sorted_vals[pos] <= it.value) pos++;
        sorted_vals.insert(pos, it.value);
      end
    end else begin
      pos = -1;
      foreach (sorted_vals[i]) begin
        if (pos < 0 && sorted_vals[i] == it.value) pos = i;
      end
      if (pos < 0) begin
        r.status = rmhs_pkg::ST_ABSENT;
      end else begin
        sorted_vals.delete(pos);
      end
    end
    n = sorted_vals.size();
    foreach (sorted_vals[i]) begin
      if (i < (n + 1) / 2) begin
        lo_sum = lo_sum + sorted_vals[i];
      end else begin
        hi_sum = hi_sum + sorted_vals[i];
      end
    end
    r.median        = (n == 0) ? '0 : sorted_vals[(n - 1) / 2];
    r.low_half_sum  = lo_sum;
    r.high_half_sum = hi_sum;
    r.entry_count   = n[rmhs_pkg::COUNT_W-1:0];
    r.is_empty      = (n == 0);
    return r;
  endfunction

  function automatic logic [rmhs_pkg::VALUE_W-1:0] rand_value();
    logic [rmhs_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = rmhs_pkg::VALUE_W'($urandom_range(0, 31)) - rmhs_pkg::VALUE_W'(16);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'd0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic offer(input rmhs_pkg::rmhs_in_t it, input bit typed,
                       input rmhs_pkg::rmhs_out_t typed_result);
    rmhs_pkg::rmhs_out_t predicted;
    while (!steady && $urandom_range(0, 99) < 28) begin
      stim_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    stim_if.valid   <= 1'b1;
    stim_if.payload <= it;
    do @(posedge clk_i); while (!stim_if.ready);
    predicted = update_median_store(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic offer_random(input int unsigned insert_pct);
    logic [rmhs_pkg::VALUE_W-1:0] v;
    if ($urandom_range(0, 99) < insert_pct) begin
      offer(mk_item(rmhs_pkg::KIND_INSERT, rand_value()), 0, '0);
    end else begin
      if (sorted_vals.size() != 0 && $urandom_range(0, 3) != 0) begin
        v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
      end else begin
        v = rand_value();
      end
      offer(mk_item(rmhs_pkg::KIND_ERASE, v), 0, '0);
    end
  endtask

  task automatic wait_drained();
    stim_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input rmhs_pkg::rmhs_out_t got);
    rmhs_pkg::rmhs_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected: %p", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.median !== want.median) begin
      $display("%0t: median expected %0d got %0d", $time, want.median, got.median);
      errors++;
    end
    if (got.low_half_sum !== want.low_half_sum) begin
      $display("%0t: low_half_sum expected %0d got %0d", $time, want.low_half_sum,
               got.low_half_sum);
      errors++;
    end
    if (got.high_half_sum !== want.high_half_sum) begin
      $display("%0t: high_half_sum expected %0d got %0d", $time, want.high_half_sum,
               got.high_half_sum);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
               got.entry_count);
      errors++;
    end
    if (got.is_empty !== want.is_empty) begin
      $display("%0t: is_empty expected %0b got %0b", $time, want.is_empty, got.is_empty);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      errors++;
    end
  endtask

  initial begin : result_side
    int unsigned taken;
    int unsigned hold_left;
    taken     = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        check_result(res_if.payload);
        taken++;
        if (taken == 150 || taken == 400) hold_left = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    steady          = 1'b0;
    errors          = 0;
    cycles          = 0;
    stim_if.valid   = 1'b0;
    stim_if.payload = '0;
    build_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

    for (int i = 0; i < 150; i++) offer_random(60);

    // Fill the store back to back, push against the full store, then free one place and fill it again.
    steady = 1'b1;
    while (sorted_vals.size() < STORE_DEPTH) begin
      offer(mk_item(rmhs_pkg::KIND_INSERT, rand_value()), 0, '0);
    end
    repeat (5) offer(mk_item(rmhs_pkg::KIND_INSERT, rand_value()), 0, '0);
    offer(mk_item(rmhs_pkg::KIND_ERASE, sorted_vals[$urandom_range(0, STORE_DEPTH - 1)]),
          0, '0);
    offer(mk_item(rmhs_pkg::KIND_INSERT, rand_value()), 0, '0);
    offer(mk_item(rmhs_pkg::KIND_INSERT, rand_value()), 0, '0);
    steady = 1'b0;

    wait_drained();

    for (int i = 0; i < 120; i++) offer_random(35);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_running_median_half_sums_unit passed");
    end else begin
      $display("tb_running_median_half_sums_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
